/* hw/rtl/u8d_pkg.sv */
// shared types and constants for the utf-8 decoder
package u8d_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] C_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] C_HIGH_FIRST  = 21'h00D800;
    localparam logic [CP_W-1:0] C_HIGH_LAST   = 21'h00DBFF;
    localparam logic [CP_W-1:0] C_LOW_FIRST   = 21'h00DC00;
    localparam logic [CP_W-1:0] C_LOW_LAST    = 21'h00DFFF;
    localparam logic [CP_W-1:0] C_SUPP_BASE   = 21'h010000;

    // lead byte prefixes
    localparam logic [2:0] C_LEAD2 = 3'b110;
    localparam logic [3:0] C_LEAD3 = 4'b1110;
    localparam logic [4:0] C_LEAD4 = 5'b11110;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_code_point;
        logic            end_of_text;
    } t_out_word;

endpackage

/* hw/rtl/u8d_core.sv */
// decoder state and single-pass byte decode logic
module u8d_core
    import u8d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    output logic      o_emit,
    output t_out_word o_word
);

    logic [1:0]      r_bytes_left, n_bytes_left;
    logic [CP_W-1:0] r_partial, n_partial;
    logic            r_high_pending, n_high_pending;
    logic [9:0]      r_high_bits, n_high_bits;

    logic [7:0]      b;
    logic            complete;
    logic            emit;
    logic [CP_W-1:0] value;
    logic [CP_W-1:0] result;
    logic [CP_W-1:0] low_off;
    logic            is_high;
    logic            is_low;

    assign b = i_word.data_byte;

    // byte merge and lead byte decode
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_partial    = r_partial;
        complete     = 1'b0;
        value        = '0;
        if (r_bytes_left != 2'd0) begin
            n_partial    = {r_partial[CP_W-7:0], b[5:0]};
            n_bytes_left = r_bytes_left - 2'd1;
            if (r_bytes_left == 2'd1) begin
                value    = n_partial;
                complete = 1'b1;
            end
        end else if (b[7] == 1'b0) begin
            value    = {{(CP_W-8){1'b0}}, b};
            complete = 1'b1;
        end else if (b[7:5] == C_LEAD2) begin
            n_partial    = {{(CP_W-5){1'b0}}, b[4:0]};
            n_bytes_left = 2'd1;
        end else if (b[7:4] == C_LEAD3) begin
            n_partial    = {{(CP_W-4){1'b0}}, b[3:0]};
            n_bytes_left = 2'd2;
        end else if (b[7:3] == C_LEAD4) begin
            n_partial    = {{(CP_W-3){1'b0}}, b[2:0]};
            n_bytes_left = 2'd3;
        end else begin
            value    = C_REPLACEMENT;
            complete = 1'b1;
        end
    end

    assign is_high = (value >= C_HIGH_FIRST) && (value <= C_HIGH_LAST);
    assign is_low  = (value >= C_LOW_FIRST) && (value <= C_LOW_LAST);
    assign low_off = value - C_LOW_FIRST;

    // surrogate pair joining
    always_comb begin
        n_high_pending = r_high_pending;
        n_high_bits    = r_high_bits;
        emit           = 1'b0;
        result         = '0;
        if (complete) begin
            if (r_high_pending) begin
                if (is_low) begin
                    result = {1'b0, r_high_bits, low_off[9:0]} + C_SUPP_BASE;
                end else begin
                    result = C_REPLACEMENT;
                end
                n_high_pending = 1'b0;
                n_high_bits    = '0;
                emit           = 1'b1;
            end else if (is_high) begin
                n_high_pending = 1'b1;
                n_high_bits    = value[9:0];
            end else begin
                result = value;
                emit   = 1'b1;
            end
        end
    end

    // result word, the final byte always gives one
    assign o_emit                = emit || i_word.last_byte;
    assign o_word.code_point     = emit ? result : '0;
    assign o_word.has_code_point = emit;
    assign o_word.end_of_text    = i_word.last_byte;

    // state update, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left   <= '0;
            r_partial      <= '0;
            r_high_pending <= 1'b0;
            r_high_bits    <= '0;
        end else if (i_step) begin
            if (i_word.last_byte) begin
                r_bytes_left   <= '0;
                r_partial      <= '0;
                r_high_pending <= 1'b0;
                r_high_bits    <= '0;
            end else begin
                r_bytes_left   <= n_bytes_left;
                r_partial      <= n_partial;
                r_high_pending <= n_high_pending;
                r_high_bits    <= n_high_bits;
            end
        end
    end

endmodule

/* hw/rtl/utf8_to_code_point_decoder_top.sv */
// utf-8 byte stream to code point decoder, top level
//
//  channel | direction | handshake                    | word
//  in      | input     | i_in_valid / o_in_ready      | t_in_word  (data_byte, last_byte)
//  out     | output    | o_out_valid / i_out_ready    | t_out_word (code_point, flags)
//
// one byte per cycle sustained while the output is not stalled; a byte waits in the
// input register and its result word is then registered in the result register.
// the decode state updates in the cycle a byte leaves the input register.
// reset (synchronous, active low) empties both registers and clears the state.
// when the result register is full and not taken, the input register holds
// and input ready drops until the result word moves on.
module utf8_to_code_point_decoder_top
    import u8d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      out_free;
    logic      step;
    logic      core_emit;
    t_out_word core_word;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    u8d_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in_word),
        .o_emit  (core_emit),
        .o_word  (core_word)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && core_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && core_emit) begin
            r_out_word <= core_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef ASSERT_OFF
    // the final byte always produces a flagged result word
    a_last_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_word.last_byte) |=> (r_out_valid && r_out_word.end_of_text))
        else $error("final byte gave no end_of_text word");

    // a word without a code point is only the end-of-text word, with zero value
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.has_code_point) |->
        (r_out_word.end_of_text && (r_out_word.code_point == '0)))
        else $error("empty word not at end of text or nonzero");

    // a high surrogate is never given out on its own
    a_no_high_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.has_code_point) |->
        !((r_out_word.code_point >= C_HIGH_FIRST) && (r_out_word.code_point <= C_HIGH_LAST)))
        else $error("unpaired high surrogate given out");
`endif

endmodule
